>>> hw/rtl/etbg_pkg.sv
package etbg_pkg;

  localparam int PHASE_BITS_DEF      = 32;
  localparam int SINE_TABLE_BITS_DEF = 10;

  localparam int FREQ_W = 17;
  localparam int RATE_W = 18;
  localparam int LEN_W  = 16;
  localparam int MUL_W  = 32;

  // taylor coefficients of sin(pi/2 x), q2.30
  localparam logic [31:0] K1 = 32'd1686629713;
  localparam logic [31:0] K3 = 32'd693598668;
  localparam logic [31:0] K5 = 32'd85569306;
  localparam logic [31:0] K7 = 32'd5026995;
  localparam logic [31:0] K9 = 32'd172272;

  localparam logic [RATE_W-1:0] RATE_RST = 18'd44100;
  localparam logic [LEN_W-1:0]  LEN_RST  = 16'd2205;

  localparam logic [1:0] REG_OUT_RATE = 2'd0;
  localparam logic [1:0] REG_LEN      = 2'd1;
  localparam logic [1:0] REG_STEREO   = 2'd2;

  typedef struct packed {
    logic [FREQ_W-1:0] tone_freq_hz;
    logic              restart;
  } in_t;

  typedef struct packed {
    logic signed [15:0] pcm_sample;
    logic               channel;
    logic               tone_end;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_EDIV, S_SQRT, S_PDIV, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_PROD, OP_DEN, OP_X2, OP_K7, OP_K5, OP_K3, OP_K1, OP_SX, OP_SCL, OP_MIX
  } mop_t;

endpackage

>>> hw/rtl/etbg_mul.sv
module etbg_mul #(
  parameter int W = etbg_pkg::MUL_W
) (
  input  logic           clk,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);

  // registered product
  always_ff @(posedge clk) begin
    p <= (2*W)'(a) * (2*W)'(b);
  end

endmodule

>>> hw/rtl/enveloped_tone_burst_generator.sv
// enveloped tone burst generator, one sample per request
// a new request is taken only while idle; each request runs 10 passes through
//   one shared multiplier, a 32-step envelope divider, a 16-step square
//   root and a (17 + PHASE_BITS)-step phase increment divider
// reset: synchronous, clears phase, frame counter and handshakes, loads register defaults
module enveloped_tone_burst_generator #(
  parameter int PHASE_BITS      = etbg_pkg::PHASE_BITS_DEF,
  parameter int SINE_TABLE_BITS = etbg_pkg::SINE_TABLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  etbg_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output etbg_pkg::out_t               out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [etbg_pkg::RATE_W-1:0]  cfg_data
);

  localparam int PDIV_STEPS = etbg_pkg::FREQ_W + PHASE_BITS;
  localparam int CNT_W      = $clog2(PDIV_STEPS + 1);
  localparam int QB         = SINE_TABLE_BITS - 2;
  localparam int FW         = etbg_pkg::FREQ_W;
  localparam int RW         = etbg_pkg::RATE_W;
  localparam int LW         = etbg_pkg::LEN_W;

  // configuration registers
  logic [RW-1:0] out_rate;
  logic [LW-1:0] samples_per_tone;
  logic          stereo;

  // block state
  logic [PHASE_BITS-1:0] phase_acc;
  logic [LW-1:0]         frame;

  // current request
  logic [PHASE_BITS-1:0] ph_cur;
  logic [LW-1:0]         n_cur;
  logic [FW-1:0]         f_cur;

  etbg_pkg::state_t state, state_next;
  etbg_pkg::mop_t   mstep;
  logic             mwait;
  logic [CNT_W-1:0] cnt;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // envelope path
  logic [31:0] prod, den, er, eq;
  logic [31:0] sv_v, sres, sbit;
  logic [16:0] env;

  // sine path
  logic [31:0] x2, pol, sv;
  logic [14:0] mag;
  logic [16:0] mix;

  // phase increment divider
  logic [RW-1:0]         pr;
  logic [PHASE_BITS-1:0] pq;
  logic [FW-1:0]         fsh;

  logic out_dup;

  // burst length, zero acts as one
  logic [LW-1:0] len;
  logic          in_burst;
  logic          tone_end;
  assign len      = (samples_per_tone == '0) ? LW'(1) : samples_per_tone;
  assign in_burst = n_cur < len;
  assign tone_end = !in_burst || (n_cur == len - LW'(1));

  // sine argument from the top table bits of the phase
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad;
  logic [QB:0]                qv;
  logic [31:0]                x;
  assign idx  = ph_cur[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad = idx[SINE_TABLE_BITS-1 -: 2];
  assign qv   = quad[0] ? ((QB+1)'(1) << QB) - {1'b0, idx[QB-1:0]} : {1'b0, idx[QB-1:0]};
  assign x    = 32'(qv) << (30 - QB);

  assign in_ready  = (state == etbg_pkg::S_IDLE);
  // registers change only with nothing in flight
  assign cfg_ready = (state == etbg_pkg::S_IDLE) && !out_valid;

  // multiplier operand select
  always_comb begin
    case (mstep)
      etbg_pkg::OP_PROD: begin
        mul_a = 32'(n_cur);
        mul_b = in_burst ? 32'(len - n_cur) : 32'd0;
      end
      etbg_pkg::OP_DEN: begin
        mul_a = 32'(len);
        mul_b = 32'(len);
      end
      etbg_pkg::OP_X2: begin
        mul_a = x;
        mul_b = x;
      end
      etbg_pkg::OP_K7: begin
        mul_a = etbg_pkg::K9;
        mul_b = x2;
      end
      etbg_pkg::OP_SX: begin
        mul_a = pol;
        mul_b = x;
      end
      etbg_pkg::OP_SCL: begin
        mul_a = sv;
        mul_b = 32'd32767;
      end
      etbg_pkg::OP_MIX: begin
        mul_a = 32'(env);
        mul_b = 32'(mag);
      end
      default: begin
        mul_a = pol;
        mul_b = x2;
      end
    endcase
  end

  etbg_mul #(.W(etbg_pkg::MUL_W)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etbg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      etbg_pkg::S_IDLE: begin
        if (in_valid) state_next = etbg_pkg::S_MUL;
      end
      etbg_pkg::S_MUL: begin
        if (mwait && mstep == etbg_pkg::OP_DEN) state_next = etbg_pkg::S_EDIV;
        else if (mwait && mstep == etbg_pkg::OP_MIX) state_next = etbg_pkg::S_PDIV;
      end
      etbg_pkg::S_EDIV: begin
        if (cnt == CNT_W'(31)) state_next = etbg_pkg::S_SQRT;
      end
      etbg_pkg::S_SQRT: begin
        if (cnt == CNT_W'(15)) state_next = etbg_pkg::S_MUL;
      end
      etbg_pkg::S_PDIV: begin
        if (cnt == CNT_W'(PDIV_STEPS - 1)) state_next = etbg_pkg::S_DONE;
      end
      etbg_pkg::S_DONE: begin
        if (!out_valid) state_next = etbg_pkg::S_IDLE;
      end
      default: state_next = etbg_pkg::S_IDLE;
    endcase
  end

  // divider and square root step values
  logic [32:0]   e_t;
  logic          e_ge;
  logic [32:0]   s_sum;
  logic          s_ge;
  logic [RW:0]   p_t;
  logic          p_ge;
  logic [63:0]   scl;
  logic [16:0]   sat_neg;
  logic signed [15:0] pcm;
  assign e_t   = {er, 1'b0};
  assign e_ge  = e_t >= {1'b0, den};
  assign s_sum = {1'b0, sres} + {1'b0, sbit};
  assign s_ge  = {1'b0, sv_v} >= s_sum;
  assign p_t   = {pr, fsh[FW-1]};
  assign p_ge  = p_t >= {1'b0, out_rate};
  assign scl   = (mul_p + 64'd536870912) >> 30;
  assign sat_neg = (mix > 17'd32768) ? 17'd32768 : mix;
  assign pcm   = (quad[1]) ? -$signed(16'(sat_neg))
                           : ((mix > 17'd32767) ? 16'sd32767 : $signed(16'(mix)));

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      out_rate         <= etbg_pkg::RATE_RST;
      samples_per_tone <= etbg_pkg::LEN_RST;
      stereo           <= 1'b0;
      phase_acc        <= '0;
      frame            <= '0;
      out_valid        <= 1'b0;
      out_dup          <= 1'b0;
      mwait            <= 1'b0;
      mstep            <= etbg_pkg::OP_PROD;
      cnt              <= '0;
    end else begin
      // config writes, taken only while idle
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          etbg_pkg::REG_OUT_RATE: out_rate         <= cfg_data;
          etbg_pkg::REG_LEN:      samples_per_tone <= cfg_data[LW-1:0];
          etbg_pkg::REG_STEREO:   stereo           <= cfg_data[0];
          default: ;
        endcase
      end

      // output register, second channel copy in stereo
      if (out_valid && out_ready) begin
        if (out_dup) begin
          out_data.channel <= 1'b1;
          out_dup          <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end

      unique case (state)
        etbg_pkg::S_IDLE: begin
          if (in_valid) begin
            // restart clears phase and frame before this sample
            ph_cur <= in_data.restart ? '0 : phase_acc;
            n_cur  <= in_data.restart ? '0 : frame;
            f_cur  <= in_data.tone_freq_hz;
            mstep  <= etbg_pkg::OP_PROD;
            mwait  <= 1'b0;
          end
        end
        etbg_pkg::S_MUL: begin
          if (!mwait) begin
            mwait <= 1'b1;
          end else begin
            mwait <= 1'b0;
            mstep <= etbg_pkg::mop_t'(mstep + 4'd1);
            case (mstep)
              etbg_pkg::OP_PROD: prod <= mul_p[31:0];
              etbg_pkg::OP_DEN: begin
                den <= mul_p[31:0];
                er  <= prod;
                eq  <= '0;
                cnt <= '0;
              end
              etbg_pkg::OP_X2: x2  <= mul_p[61:30];
              etbg_pkg::OP_K7: pol <= etbg_pkg::K7 - mul_p[61:30];
              etbg_pkg::OP_K5: pol <= etbg_pkg::K5 - mul_p[61:30];
              etbg_pkg::OP_K3: pol <= etbg_pkg::K3 - mul_p[61:30];
              etbg_pkg::OP_K1: pol <= etbg_pkg::K1 - mul_p[61:30];
              etbg_pkg::OP_SX: sv  <= mul_p[61:30];
              etbg_pkg::OP_SCL: mag <= (scl > 64'd32767) ? 15'd32767 : scl[14:0];
              etbg_pkg::OP_MIX: begin
                mix <= mul_p[32:16];
                pr  <= '0;
                pq  <= '0;
                fsh <= f_cur;
                cnt <= '0;
              end
              default: ;
            endcase
          end
        end
        etbg_pkg::S_EDIV: begin
          // prod * 2^32 / den, one quotient bit a cycle
          er  <= e_ge ? 32'(e_t - {1'b0, den}) : e_t[31:0];
          eq  <= {eq[30:0], e_ge};
          cnt <= (cnt == CNT_W'(31)) ? '0 : cnt + CNT_W'(1);
          if (cnt == CNT_W'(31)) begin
            sv_v <= {eq[30:0], e_ge};
            sres <= '0;
            sbit <= 32'h4000_0000;
          end
        end
        etbg_pkg::S_SQRT: begin
          // bitwise integer square root
          if (s_ge) begin
            sv_v <= 32'({1'b0, sv_v} - s_sum);
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          cnt  <= (cnt == CNT_W'(15)) ? '0 : cnt + CNT_W'(1);
          if (cnt == CNT_W'(15)) begin
            env   <= s_ge ? 17'((sres >> 1) + sbit) : 17'(sres >> 1);
            mstep <= etbg_pkg::OP_X2;
            mwait <= 1'b0;
          end
        end
        etbg_pkg::S_PDIV: begin
          // frac(f / out_rate) * 2^PHASE_BITS by long division
          pr  <= p_ge ? RW'(p_t - {1'b0, out_rate}) : p_t[RW-1:0];
          pq  <= {pq[PHASE_BITS-2:0], p_ge};
          fsh <= {fsh[FW-2:0], 1'b0};
          cnt <= cnt + CNT_W'(1);
        end
        etbg_pkg::S_DONE: begin
          if (!out_valid) begin
            out_data.pcm_sample <= pcm;
            out_data.channel    <= 1'b0;
            out_data.tone_end   <= tone_end;
            out_valid           <= 1'b1;
            out_dup             <= stereo;
            // zero sample rate holds the phase
            phase_acc <= ph_cur + ((out_rate == '0) ? '0 : pq);
            frame     <= tone_end ? '0 : n_cur + LW'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule
